// ===== rtl/rbd_pkg.sv =====
// Shared types and constants for the Rice bitstream decoder.
// Used by rbd_front, rbd_back and rice_bitstream_decoder; no dependencies.
`default_nettype none

package rbd_pkg;

   // Stream geometry
   localparam int BITS_PER_BYTE    = 8;
   localparam int HEADER_BITS_LAST = 2;
   localparam int BIT_IDX_W        = $clog2(BITS_PER_BYTE);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result kinds
   typedef enum logic [1:0] {
      KIND_SYMBOL    = 2'd0,
      KIND_END       = 2'd1,
      KIND_EARLY_END = 2'd2
   } result_kind_type;

   // Word class set by the front end
   typedef enum logic {
      ITEM_DATA = 1'b0,
      ITEM_END  = 1'b1
   } item_class_type;

   // Queue entry
   typedef struct packed {
      item_class_type cls;
      logic [7:0]     data_byte;
   } item_type;

   // Decode phase, one-hot
   typedef enum logic [2:0] {
      PH_HEADER    = 3'b001,
      PH_UNARY     = 3'b010,
      PH_REMAINDER = 3'b100
   } phase_type;

endpackage : rbd_pkg

`default_nettype wire

// ===== rtl/rbd_front.sv =====
// Front end: accepts input words, classifies them and queues them.
// Depends on rbd_pkg.
`default_nettype none

module rbd_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_data_byte,
   input  wire logic          req_end_of_stream,
   output logic               head_valid,
   output rbd_pkg::item_type  head_item,
   input  wire logic          head_pop
);
   import rbd_pkg::*;

   item_type                 queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push;
   logic                     pop;
   item_type                 new_item;

   // Classify the incoming word
   always_comb begin
      new_item.cls       = req_end_of_stream ? ITEM_END : ITEM_DATA;
      new_item.data_byte = req_data_byte;
   end

   assign req_stall  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_item  = queue_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule : rbd_front

`default_nettype wire

// ===== rtl/rbd_back.sv =====
// Back end: bit-serial Rice decode of queued words, one stream bit per cycle unless paused
// by a held result, with a pending-result stage and the output register. Depends on rbd_pkg.
`default_nettype none

module rbd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire rbd_pkg::item_type  head_item,
   output logic                    head_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_decoded_value,
   output logic [1:0]              rsp_result_kind,
   output logic                    rsp_last_of_run
);
   import rbd_pkg::*;

   // Decoder state
   phase_type               phase_ff, phase_in;
   logic [1:0]              hdr_cnt_ff, hdr_cnt_in;
   logic [2:0]              rice_k_ff, rice_k_in;
   logic [7:0]              quot_ff, quot_in;
   logic [6:0]              rem_acc_ff, rem_acc_in;
   logic [2:0]              rem_left_ff, rem_left_in;
   logic [BIT_IDX_W-1:0]    bit_idx_ff, bit_idx_in;

   // Pending result and output register
   logic                    pend_valid_ff, pend_valid_in;
   logic                    pend_final_ff, pend_final_in;
   logic [7:0]              pend_value_ff, pend_value_in;
   result_kind_type         pend_kind_ff, pend_kind_in;
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_value_ff, out_value_in;
   result_kind_type         out_kind_ff, out_kind_in;
   logic                    out_last_ff, out_last_in;

   // Step signals
   logic                    cur_bit;
   logic                    byte_end;
   logic                    sym;
   logic [7:0]              sym_value;
   result_kind_type         sym_kind;
   logic [7:0]              rem_word;
   logic [2:0]              rem_left_dec;
   logic                    out_free;
   logic                    step_ok;
   logic                    step;
   logic                    move;

   assign cur_bit  = head_item.data_byte[bit_idx_ff];
   assign byte_end = (head_item.cls == ITEM_END) ||
                     (bit_idx_ff == BIT_IDX_W'(BITS_PER_BYTE - 1));
   assign rem_word     = {rem_acc_ff, cur_bit};
   assign rem_left_dec = rem_left_ff - 3'd1;

   // Next decoder state for the current bit or end word
   always_comb begin
      phase_in    = phase_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      rice_k_in   = rice_k_ff;
      quot_in     = quot_ff;
      rem_acc_in  = rem_acc_ff;
      rem_left_in = rem_left_ff;
      sym         = 1'b0;
      sym_value   = '0;
      sym_kind    = KIND_SYMBOL;
      if (head_item.cls == ITEM_END) begin
         sym         = 1'b1;
         sym_kind    = (phase_ff == PH_UNARY || phase_ff == PH_REMAINDER) ?
                       KIND_END : KIND_EARLY_END;
         phase_in    = PH_HEADER;
         hdr_cnt_in  = '0;
         rice_k_in   = '0;
         quot_in     = '0;
         rem_acc_in  = '0;
         rem_left_in = '0;
      end else begin
         unique case (phase_ff)
            PH_UNARY: begin
               if (cur_bit) begin
                  quot_in = quot_ff + 8'd1;
               end else if (rice_k_ff == '0) begin
                  sym       = 1'b1;
                  sym_value = quot_ff;
                  quot_in   = '0;
               end else begin
                  phase_in    = PH_REMAINDER;
                  rem_acc_in  = '0;
                  rem_left_in = rice_k_ff;
               end
            end
            PH_REMAINDER: begin
               rem_left_in = rem_left_dec;
               if (rem_left_dec == '0) begin
                  sym        = 1'b1;
                  sym_value  = (quot_ff << rice_k_ff) | rem_word;
                  quot_in    = '0;
                  rem_acc_in = '0;
                  phase_in   = PH_UNARY;
               end else begin
                  rem_acc_in = rem_word[6:0];
               end
            end
            default: begin
               rice_k_in = {rice_k_ff[1:0], cur_bit};
               if (hdr_cnt_ff >= 2'(HEADER_BITS_LAST)) begin
                  hdr_cnt_in  = '0;
                  phase_in    = PH_UNARY;
                  quot_in     = '0;
                  rem_acc_in  = '0;
                  rem_left_in = '0;
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 2'd1;
               end
            end
         endcase
      end
   end

   // Handshake between bit engine, pending stage and output register
   assign out_free = !out_valid_ff || !rsp_stall;
   assign step_ok  = !pend_valid_ff || out_free || (!sym && !byte_end);
   assign step     = head_valid && step_ok;
   assign head_pop = step && byte_end;
   assign move     = pend_valid_ff && out_free &&
                     (pend_final_ff || (step && (sym || byte_end)));

   // Bit position within the current word
   always_comb begin
      bit_idx_in = bit_idx_ff;
      if (step) begin
         bit_idx_in = byte_end ? '0 : bit_idx_ff + 1'b1;
      end
   end

   // Pending result: held until the next result or the word end shows its last flag
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_value_in = pend_value_ff;
      pend_kind_in  = pend_kind_ff;
      if (step && sym) begin
         pend_valid_in = 1'b1;
         pend_final_in = byte_end;
         pend_value_in = sym_value;
         pend_kind_in  = sym_kind;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_value_in = pend_value_ff;
         out_kind_in  = pend_kind_ff;
         out_last_in  = pend_final_ff || (step && byte_end && !sym);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_cnt_ff    <= '0;
         rice_k_ff     <= '0;
         quot_ff       <= '0;
         rem_acc_ff    <= '0;
         rem_left_ff   <= '0;
         bit_idx_ff    <= '0;
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (step) begin
            phase_ff    <= phase_in;
            hdr_cnt_ff  <= hdr_cnt_in;
            rice_k_ff   <= rice_k_in;
            quot_ff     <= quot_in;
            rem_acc_ff  <= rem_acc_in;
            rem_left_ff <= rem_left_in;
         end
         bit_idx_ff    <= bit_idx_in;
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      pend_kind_ff  <= pend_kind_in;
      out_value_ff  <= out_value_in;
      out_kind_ff   <= out_kind_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_decoded_value = out_value_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_last_of_run   = out_last_ff;

endmodule : rbd_back

`default_nettype wire

// ===== rtl/rice_bitstream_decoder.sv =====
// Rice bitstream decoder top: rbd_front word queue feeding rbd_back (uses rbd_pkg).
// Throughput: data words are decoded one stream bit per cycle, an end word is taken whole;
// the engine pauses while a finished result cannot move on; the 2-word queue fills meanwhile.
// Path: a symbol whose bit ends the word passes the pending and output registers to rsp_valid;
// else it waits for the next symbol or word end; an idle end word first passes the queue.
// Reset (synchronous): empties queue and output, returns the decoder to the header phase.
`default_nettype none

module rice_bitstream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_decoded_value,
   output logic [1:0]       rsp_result_kind,
   output logic             rsp_last_of_run
);
   import rbd_pkg::*;

   logic      head_valid;
   item_type  head_item;
   logic      head_pop;

   // Accept and queue words
   rbd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .head_pop          (head_pop)
   );

   // Decode and deliver results
   rbd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule : rice_bitstream_decoder

`default_nettype wire

// ===== dv/tb_rice_bitstream_decoder.sv =====
// Self-checking testbench for rice_bitstream_decoder: directed and random compressed
// streams, checked symbol by symbol against an in-bench bit-serial decoder.
// Depends on rbd_pkg and the rice_bitstream_decoder RTL.
`timescale 1ns / 1ps

module tb_rice_bitstream_decoder;
   import rbd_pkg::*;

   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 32;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [7:0]      value;
      result_kind_type kind;
      logic            is_last;
   } symbol_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_end_of_stream = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_decoded_value;
   logic [1:0] rsp_result_kind;
   logic       rsp_last_of_run;

   // Traffic shaping
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_req = 1'b0;
   int   hold_left = 0;

   // Decoder shadow state
   phase_type  dec_phase = PH_HEADER;
   logic [1:0] hdr_count = 2'd0;
   logic [2:0] k_param = 3'd0;
   logic [7:0] quot = 8'd0;
   logic [6:0] rem_acc = 7'd0;
   logic [2:0] rem_left = 3'd0;

   symbol_type expected_symbols[$];
   int         mismatch_count = 0;

   rice_bitstream_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result-side stall: random, plus a long counted hold on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left != 0) hold_left <= hold_left - 1;
         else if (hold_req) hold_left <= HOLD_CYCLES;
         rsp_stall <= (hold_left > 1) || hold_req || ($urandom_range(99) < stall_pct);
      end
   end

   // Symbol value: shifted quotient or'ed with remainder, low byte only
   function automatic logic [7:0] symbol_value(input logic [7:0] rem);
      logic [15:0] shifted;
      shifted = ({8'd0, quot} << k_param) | {8'd0, rem};
      return shifted[7:0];
   endfunction

   task automatic clear_decoder();
      dec_phase = PH_HEADER;
      hdr_count = 2'd0;
      k_param   = 3'd0;
      quot      = 8'd0;
      rem_acc   = 7'd0;
      rem_left  = 3'd0;
   endtask

   // Walk one accepted word through the shadow decoder, queue its symbols
   task automatic decode_word(input logic [7:0] data, input logic eos);
      symbol_type found[$];
      symbol_type s;
      logic       bit_in;
      logic [7:0] acc;
      if (eos) begin
         s.value   = 8'd0;
         s.kind    = (dec_phase == PH_UNARY || dec_phase == PH_REMAINDER) ?
                     KIND_END : KIND_EARLY_END;
         s.is_last = 1'b1;
         expected_symbols.push_back(s);
         clear_decoder();
         return;
      end
      for (int i = 0; i < BITS_PER_BYTE; i++) begin
         bit_in = data[i];
         case (dec_phase)
            PH_UNARY: begin
               if (bit_in) begin
                  quot = quot + 8'd1;
               end else if (k_param == 3'd0) begin
                  s.value = symbol_value(8'd0);
                  s.kind  = KIND_SYMBOL;
                  found.push_back(s);
                  quot = 8'd0;
               end else begin
                  dec_phase = PH_REMAINDER;
                  rem_acc   = 7'd0;
                  rem_left  = k_param;
               end
            end
            PH_REMAINDER: begin
               acc      = {rem_acc, bit_in};
               rem_left = rem_left - 3'd1;
               if (rem_left == 3'd0) begin
                  s.value = symbol_value(acc);
                  s.kind  = KIND_SYMBOL;
                  found.push_back(s);
                  quot      = 8'd0;
                  rem_acc   = 7'd0;
                  dec_phase = PH_UNARY;
               end else begin
                  rem_acc = acc[6:0];
               end
            end
            default: begin
               // header: first bit lands in the MSB of k
               k_param = {k_param[1:0], bit_in};
               if (hdr_count >= 2'(HEADER_BITS_LAST)) begin
                  hdr_count = 2'd0;
                  dec_phase = PH_UNARY;
                  quot      = 8'd0;
                  rem_acc   = 7'd0;
                  rem_left  = 3'd0;
               end else begin
                  hdr_count = hdr_count + 2'd1;
               end
            end
         endcase
      end
      foreach (found[j]) begin
         s         = found[j];
         s.is_last = (j == found.size() - 1);
         expected_symbols.push_back(s);
      end
   endtask

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      symbol_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_symbols.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected result: value %0d kind %0d last %0b",
                        rsp_decoded_value, rsp_result_kind, rsp_last_of_run);
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_decoded_value !== want.value || rsp_result_kind !== want.kind ||
                rsp_last_of_run !== want.is_last) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < MAX_REPORTS)
                  $display("mismatch: expected value %0d kind %0d last %0b, got %0d %0d %0b",
                           want.value, want.kind, want.is_last, rsp_decoded_value,
                           rsp_result_kind, rsp_last_of_run);
            end
         end
      end
   end

   // Offer one word, with random idle gaps ahead of it; valid stays up after acceptance
   task automatic send_word(input logic [7:0] data, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_word(data, eos);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_symbols.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct    <= recv_pct;
   endtask

   function automatic logic [7:0] stream_byte();
      case ($urandom_range(3))
         0:       return 8'($urandom_range(255));
         1:       return 8'($urandom & $urandom);   // mostly zeros: short symbols
         2:       return 8'($urandom | $urandom);   // mostly ones: long quotients
         default: return $urandom_range(1) ? 8'h00 : 8'hFF;
      endcase
   endfunction

   // Hand-built streams: header order, k = 0 and k = 7, full bytes of symbols
   task automatic test_directed();
      send_word(8'hFF, 1'b1);   // end before any header, data ignored
      send_word(8'h00, 1'b1);   // and again
      send_word(8'h00, 1'b0);   // k = 0, five zero symbols
      send_word(8'h00, 1'b0);   // eight symbols in one word
      send_word(8'hFF, 1'b0);   // quotient builds, no result
      send_word(8'h55, 1'b0);
      send_word(8'hAA, 1'b1);   // normal end
      send_word(8'h1F, 1'b0);   // k = 7, quotient 2 shifted out of the byte
      send_word(8'hA5, 1'b0);
      send_word(8'h5A, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'h01, 1'b0);   // header 1,0,0: k = 4
      send_word(8'hC3, 1'b0);
      send_word(8'h3C, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'h02, 1'b0);   // k = 2, ends inside a remainder
      send_word(8'hFF, 1'b1);   // partial symbol dropped
      send_word(8'h04, 1'b0);   // k = 1
      send_word(8'h80, 1'b0);
      send_word(8'h7F, 1'b1);   // end during unary part
   endtask

   // Long hold on the result side while dense words keep coming
   task automatic test_backpressure();
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      send_word(8'h00, 1'b1);
      repeat (15) send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b1);
   endtask

   // Mostly well-formed streams, with stray end words and loose bytes mixed in
   task automatic test_random_streams(input int n_words);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            send_word(8'($urandom_range(255)), 1'b1);
            sent++;
         end else if (pick < 18) begin
            send_word(stream_byte(), 1'b0);
            sent++;
         end else begin
            len = $urandom_range(1, 6);
            send_word(8'($urandom_range(255)), 1'b0);
            repeat (len) send_word(stream_byte(), 1'b0);
            send_word(8'($urandom_range(255)), 1'b1);
            sent += len + 2;
         end
      end
   endtask

   // Quotient past 255 ones wraps to its low byte
   task automatic test_quotient_wrap();
      send_word(8'h00, 1'b1);
      send_word({5'b11111, 3'($urandom_range(7))}, 1'b0);
      repeat (32) send_word(8'hFF, 1'b0);
      send_word(8'($urandom_range(254)), 1'b0);
      send_word(stream_byte(), 1'b0);
      send_word(8'h00, 1'b1);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idle(0, 0);
      test_directed();
      wait_drained();
      test_backpressure();
      wait_drained();

      set_idle(0, 0);
      test_random_streams(60);
      wait_drained();
      set_idle(88, 0);
      test_random_streams(60);
      wait_drained();
      set_idle(0, 88);
      test_random_streams(60);
      wait_drained();
      set_idle(23, 23);
      test_random_streams(60);
      test_quotient_wrap();
      wait_drained();

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rbd_pkg.sv
rtl/rbd_front.sv
rtl/rbd_back.sv
rtl/rice_bitstream_decoder.sv
dv/tb_rice_bitstream_decoder.sv
